>>> src/tgra_pkg.sv
// shared types, constants and helpers of the tile grid region allocator
// no dependencies
package tgra_pkg;

  localparam int unsigned MaxGrids  = 16;
  localparam int unsigned GridSide  = 8;
  localparam int unsigned GridTiles = GridSide * GridSide;

  // command codes
  localparam logic CmdClear = 1'b0;
  localparam logic CmdPlace = 1'b1;

  // status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_ERROR    = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // answer of the row fit unit
  typedef struct packed {
    logic       hit;
    logic [2:0] x;
  } fit_t;

  // low w bits set, w in 0..8
  function automatic logic [7:0] width_mask(input logic [3:0] w);
    logic [8:0] m;
    m = (9'd1 << w) - 9'd1;
    return m[7:0];
  endfunction

  // tiles covered by a w x h rectangle at column x, row y
  function automatic logic [63:0] rect_mask(input logic [3:0] w, input logic [3:0] h,
                                            input logic [2:0] x, input logic [2:0] y);
    logic [63:0] m;
    logic [7:0]  row;
    m   = '0;
    row = width_mask(w) << x;
    for (int r = 0; r < 8; r++) begin
      if ((4'(r) >= {1'b0, y}) && (4'(r) < ({1'b0, y} + h))) begin
        m[r*8 +: 8] = row;
      end
    end
    return m;
  endfunction

endpackage

>>> src/tgra_row_fit.sv
// row fit unit: finds the leftmost free column for a rectangle at one row
// depends on tgra_pkg
module tgra_row_fit (
  input  logic [63:0]     occ_i,
  input  logic [2:0]      row_i,
  input  logic [3:0]      w_i,
  input  logic [3:0]      h_i,
  output tgra_pkg::fit_t  fit_o
);

  logic [7:0] comb_row;
  logic [7:0] wmask;

  // merge the occupied columns of the rows the rectangle would cover
  always_comb begin
    comb_row = '0;
    for (int r = 0; r < 8; r++) begin
      if ((4'(r) >= {1'b0, row_i}) && (4'(r) < ({1'b0, row_i} + h_i))) begin
        comb_row = comb_row | occ_i[r*8 +: 8];
      end
    end
  end

  assign wmask = tgra_pkg::width_mask(w_i);

  // leftmost free column wins
  always_comb begin
    fit_o = '0;
    for (int x = 7; x >= 0; x--) begin
      if (((4'(x) + w_i) <= 4'd8) && (((comb_row >> x) & wmask) == 8'd0)) begin
        fit_o.hit = 1'b1;
        fit_o.x   = 3'(x);
      end
    end
  end

endmodule

>>> src/tile_grid_region_allocator.sv
// tile grid region allocator top level: sequencer, grid store and result register
// depends on tgra_pkg and tgra_row_fit
//
// Usage: an item is taken on a rising edge with start_i high and busy_o low.
// A clear command (command_i = 0) empties all grids and opens
// ceil(tiles_needed_i / 64) of them (an error if over 16 are needed); a place
// command (command_i = 1) looks for a free rect_width_i x rect_height_i area,
// first fit over grids, rows, columns. Each item gives one result beat, shown
// for one cycle with done_o high. A clear or a rejected size answers in the
// cycle after the accept. A place scans one candidate row per cycle through
// the row fit unit, rows 0 to 8 - height of each open grid, skipping a full
// grid in one step; busy_o stays high meanwhile.
// The next item may be accepted in the cycle that shows a result.
// Reset empties the store and closes all grids; no clearing pass is needed.
// The receiver cannot stall: each result beat is gone after its cycle.
module tile_grid_region_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [10:0] tiles_needed_i,
  input  logic [3:0]  rect_width_i,
  input  logic [3:0]  rect_height_i,
  input  logic        allow_append_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  grid_index_o,
  output logic [2:0]  pos_x_o,
  output logic [2:0]  pos_y_o,
  output logic [3:0]  placed_width_o,
  output logic [3:0]  placed_height_o,
  output logic [4:0]  open_grids_o
);

  tgra_pkg::state_e state_q, state_d;
  logic [63:0] occ_q [tgra_pkg::MaxGrids];
  logic [63:0] occ_d [tgra_pkg::MaxGrids];
  logic [6:0]  used_q [tgra_pkg::MaxGrids];
  logic [6:0]  used_d [tgra_pkg::MaxGrids];
  logic [4:0]  total_q, total_d;
  logic [4:0]  grid_q, grid_d;
  logic [2:0]  row_q, row_d;
  logic [3:0]  w_q, w_d;
  logic [3:0]  h_q, h_d;
  logic        app_q, app_d;
  logic        done_q, done_d;
  tgra_pkg::status_e status_q, status_d;
  logic [3:0]  gidx_q, gidx_d;
  logic [2:0]  px_q, px_d;
  logic [2:0]  py_q, py_d;
  logic [3:0]  pw_q, pw_d;
  logic [3:0]  ph_q, ph_d;

  logic [3:0]      gsel;
  logic [63:0]     occ_cur;
  tgra_pkg::fit_t  fit;
  logic [5:0]      need;
  logic [6:0]      area;
  logic            size_bad;
  logic [11:0]     tiles_up;

  assign gsel    = grid_q[3:0];
  assign occ_cur = occ_q[gsel];
  assign area    = {3'b000, w_q} * {3'b000, h_q};

  // grids needed for a clear
  assign tiles_up = {1'b0, tiles_needed_i} + 12'(tgra_pkg::GridTiles - 1);
  assign need     = tiles_up[11:6];

  assign size_bad = (rect_width_i == 4'd0) || (rect_width_i > 4'(tgra_pkg::GridSide)) ||
                    (rect_height_i == 4'd0) || (rect_height_i > 4'(tgra_pkg::GridSide));

  // shared row fit unit
  tgra_row_fit u_row_fit (
    .occ_i (occ_cur),
    .row_i (row_q),
    .w_i   (w_q),
    .h_i   (h_q),
    .fit_o (fit)
  );

  // sequencer: next state, store updates and result
  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    used_d   = used_q;
    total_d  = total_q;
    grid_d   = grid_q;
    row_d    = row_q;
    w_d      = w_q;
    h_d      = h_q;
    app_d    = app_q;
    done_d   = 1'b0;
    status_d = status_q;
    gidx_d   = gidx_q;
    px_d     = px_q;
    py_d     = py_q;
    pw_d     = pw_q;
    ph_d     = ph_q;

    case (state_q)
      tgra_pkg::ST_IDLE: begin
        if (start_i) begin
          // default answer fields for everything but a placement
          gidx_d = '0;
          px_d   = '0;
          py_d   = '0;
          pw_d   = '0;
          ph_d   = '0;
          if (command_i == tgra_pkg::CmdClear) begin
            done_d = 1'b1;
            if (need > 6'(tgra_pkg::MaxGrids)) begin
              status_d = tgra_pkg::STATUS_ERROR;
            end else begin
              status_d = tgra_pkg::STATUS_OK;
              total_d  = need[4:0];
              for (int g = 0; g < tgra_pkg::MaxGrids; g++) begin
                occ_d[g]  = '0;
                used_d[g] = '0;
              end
            end
          end else if (size_bad) begin
            done_d   = 1'b1;
            status_d = tgra_pkg::STATUS_ERROR;
          end else begin
            w_d     = rect_width_i;
            h_d     = rect_height_i;
            app_d   = allow_append_i;
            grid_d  = '0;
            row_d   = '0;
            state_d = tgra_pkg::ST_SCAN;
          end
        end
      end

      tgra_pkg::ST_SCAN: begin
        if (grid_q >= total_q) begin
          // open grids exhausted
          done_d  = 1'b1;
          state_d = tgra_pkg::ST_IDLE;
          if (!app_q) begin
            status_d = tgra_pkg::STATUS_NO_SPACE;
          end else if (total_q >= 5'(tgra_pkg::MaxGrids)) begin
            status_d = tgra_pkg::STATUS_ERROR;
          end else begin
            status_d              = tgra_pkg::STATUS_OK;
            occ_d[total_q[3:0]]  = tgra_pkg::rect_mask(w_q, h_q, 3'd0, 3'd0);
            used_d[total_q[3:0]] = area;
            total_d               = total_q + 5'd1;
            gidx_d                = total_q[3:0];
            pw_d                  = w_q;
            ph_d                  = h_q;
          end
        end else if (used_q[gsel] >= 7'(tgra_pkg::GridTiles)) begin
          // full grid, skip it
          grid_d = grid_q + 5'd1;
          row_d  = '0;
        end else if (fit.hit) begin
          // first fit: mark tiles and report
          done_d       = 1'b1;
          state_d      = tgra_pkg::ST_IDLE;
          status_d     = tgra_pkg::STATUS_OK;
          occ_d[gsel]  = occ_cur | tgra_pkg::rect_mask(w_q, h_q, fit.x, row_q);
          used_d[gsel] = used_q[gsel] + area;
          gidx_d       = gsel;
          px_d         = fit.x;
          py_d         = row_q;
          pw_d         = w_q;
          ph_d         = h_q;
        end else if (({1'b0, row_q} + h_q) >= 4'(tgra_pkg::GridSide)) begin
          // last candidate row of this grid
          grid_d = grid_q + 5'd1;
          row_d  = '0;
        end else begin
          row_d = row_q + 3'd1;
        end
      end

      default: begin
        state_d = tgra_pkg::ST_IDLE;
      end
    endcase
  end

  // state and store registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tgra_pkg::ST_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
      for (int g = 0; g < tgra_pkg::MaxGrids; g++) begin
        occ_q[g]  <= '0;
        used_q[g] <= '0;
      end
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= done_d;
      occ_q   <= occ_d;
      used_q  <= used_d;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    grid_q   <= grid_d;
    row_q    <= row_d;
    w_q      <= w_d;
    h_q      <= h_d;
    app_q    <= app_d;
    status_q <= status_d;
    gidx_q   <= gidx_d;
    px_q     <= px_d;
    py_q     <= py_d;
    pw_q     <= pw_d;
    ph_q     <= ph_d;
  end

  // result beat
  assign busy_o          = (state_q != tgra_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign grid_index_o    = gidx_q;
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign placed_width_o  = pw_q;
  assign placed_height_o = ph_q;
  assign open_grids_o    = total_q;

endmodule
